// ===== rtl/core/sflpq_pkg.sv =====
// shared types, codes and constants of the four-level priority queue
package sflpq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int LEVELS_DEF   = 4;

   localparam int LEVEL_W  = 2;
   localparam int ID_W     = 16;
   localparam int TICKET_W = 16;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = LEVEL_W + TICKET_W + ID_W;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_ENQUEUED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DEQUEUED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

// ===== rtl/core/sflpq_ctrl.sv =====
// controller: accepts a transaction, runs the commit cycle, owns the result valid
module sflpq_ctrl import sflpq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // a new transaction only when the result register is free or draining
   assign req_stall   = reset ||
                        !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign cmd.capture = req_valid && !req_stall;
   assign cmd.commit  = (state_ff == S_EXEC);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) rsp_valid_in = 1'b1;
      else            rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/sflpq_dpath.sv =====
// datapath: entry and link memories, level chains, free list and result register
module sflpq_dpath import sflpq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int LEVELS   = LEVELS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic                req_action,
   input  logic [LEVEL_W-1:0]  req_level,
   input  logic [ID_W-1:0]     req_item_id,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [TICKET_W-1:0] rsp_ticket,
   output logic [LEVEL_W-1:0]  rsp_out_level,
   output logic [ID_W-1:0]     rsp_out_id
);

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   logic [ENTRY_W-1:0] entry_mem [CAPACITY];
   logic [SLOT_W-1:0]  link_mem  [CAPACITY];
   logic [ENTRY_W-1:0] entry_rd_ff;
   logic [SLOT_W-1:0]  link_rd_ff;

   logic [SLOT_W-1:0]   heads_ff [LEVELS];
   logic [SLOT_W-1:0]   tails_ff [LEVELS];
   logic [LEVELS-1:0]   nonempty_ff;
   logic [SLOT_W-1:0]   free_head_ff;
   logic [CNT_W-1:0]    occupancy_ff;
   logic [CNT_W-1:0]    fresh_ff;
   logic [TICKET_W-1:0] ticket_ctr_ff;

   logic                action_ff;
   logic [LVL_W-1:0]    lvl_ff;
   logic [ID_W-1:0]     id_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic                hit_ff;
   logic                from_fresh_ff;

   logic [STATUS_W-1:0] status_ff;
   logic [TICKET_W-1:0] ticket_ff;
   logic [LEVEL_W-1:0]  out_level_ff;
   logic [ID_W-1:0]     out_id_ff;

   logic [LVL_W-1:0]  enq_lvl;
   logic [LVL_W-1:0]  deq_lvl;
   logic              any_nonempty;
   logic              is_full;
   logic              fresh_left;
   logic [SLOT_W-1:0] enq_slot;
   logic [SLOT_W-1:0] deq_slot;
   logic [SLOT_W-1:0] link_rd_addr;
   logic              link_we;
   logic [SLOT_W-1:0] link_wr_addr;
   logic [SLOT_W-1:0] link_wr_data;
   logic              enq_commit;
   logic              deq_commit;

   always_comb begin
      if (32'(req_level) >= LEVELS) enq_lvl = LVL_W'(LEVELS - 1);
      else                          enq_lvl = LVL_W'(req_level);
   end

   // most urgent non-empty level
   always_comb begin
      deq_lvl = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) deq_lvl = LVL_W'(i);
      end
   end

   assign any_nonempty = |nonempty_ff;
   assign is_full      = (occupancy_ff == CNT_W'(CAPACITY));
   // slots never used since reset are handed out in order before the free list
   assign fresh_left   = (fresh_ff != CNT_W'(CAPACITY));
   assign enq_slot     = fresh_left ? fresh_ff[SLOT_W-1:0] : free_head_ff;
   assign deq_slot     = heads_ff[deq_lvl];
   assign link_rd_addr = (req_action == ACT_DEQUEUE) ? deq_slot : free_head_ff;

   assign enq_commit   = cmd.commit && hit_ff && (action_ff == ACT_ENQUEUE);
   assign deq_commit   = cmd.commit && hit_ff && (action_ff == ACT_DEQUEUE);
   assign link_we      = deq_commit || (enq_commit && nonempty_ff[lvl_ff]);
   assign link_wr_addr = (action_ff == ACT_ENQUEUE) ? tails_ff[lvl_ff] : slot_ff;
   assign link_wr_data = (action_ff == ACT_ENQUEUE) ? slot_ff : free_head_ff;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         entry_rd_ff <= entry_mem[deq_slot];
         link_rd_ff  <= link_mem[link_rd_addr];
      end
      if (enq_commit) begin
         entry_mem[slot_ff] <= {LEVEL_W'(lvl_ff), ticket_ctr_ff, id_ff};
      end
      if (link_we) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff     <= req_action;
         id_ff         <= req_item_id;
         from_fresh_ff <= fresh_left;
         if (req_action == ACT_ENQUEUE) begin
            lvl_ff  <= enq_lvl;
            slot_ff <= enq_slot;
            hit_ff  <= !is_full;
         end else begin
            lvl_ff  <= deq_lvl;
            slot_ff <= deq_slot;
            hit_ff  <= any_nonempty;
         end
      end
   end

   // queue control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            heads_ff[i] <= '0;
            tails_ff[i] <= '0;
         end
         nonempty_ff   <= '0;
         free_head_ff  <= '0;
         occupancy_ff  <= '0;
         fresh_ff      <= '0;
         ticket_ctr_ff <= '0;
      end else begin
         if (cmd.capture && (req_action == ACT_ENQUEUE)) begin
            ticket_ctr_ff <= ticket_ctr_ff + TICKET_W'(1);
         end
         if (enq_commit) begin
            if (!nonempty_ff[lvl_ff]) heads_ff[lvl_ff] <= slot_ff;
            tails_ff[lvl_ff]    <= slot_ff;
            nonempty_ff[lvl_ff] <= 1'b1;
            occupancy_ff        <= occupancy_ff + CNT_W'(1);
            if (from_fresh_ff) fresh_ff     <= fresh_ff + CNT_W'(1);
            else               free_head_ff <= link_rd_ff;
         end
         if (deq_commit) begin
            if (slot_ff == tails_ff[lvl_ff]) nonempty_ff[lvl_ff] <= 1'b0;
            else                             heads_ff[lvl_ff]    <= link_rd_ff;
            free_head_ff <= slot_ff;
            occupancy_ff <= occupancy_ff - CNT_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (action_ff == ACT_ENQUEUE) begin
            status_ff    <= hit_ff ? STAT_ENQUEUED : STAT_FULL;
            ticket_ff    <= ticket_ctr_ff;
            out_level_ff <= '0;
            out_id_ff    <= '0;
         end else if (hit_ff) begin
            status_ff    <= STAT_DEQUEUED;
            ticket_ff    <= entry_rd_ff[ID_W +: TICKET_W];
            out_level_ff <= entry_rd_ff[ID_W+TICKET_W +: LEVEL_W];
            out_id_ff    <= entry_rd_ff[ID_W-1:0];
         end else begin
            status_ff    <= STAT_EMPTY;
            ticket_ff    <= '0;
            out_level_ff <= '0;
            out_id_ff    <= '0;
         end
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_ticket    = ticket_ff;
   assign rsp_out_level = out_level_ff;
   assign rsp_out_id    = out_id_ff;

endmodule

// ===== rtl/core/stable_four_level_priority_queue.sv =====
// four-level priority queue, shared slot storage, fifo order within a level
// after acceptance the commit state loads the result register and its valid
// a transaction is a memory read cycle then a commit cycle; the next waits for the commit
// a waiting result does not block the next transaction unless it is still stalled
// reset: synchronous, empties every level and zeroes the ticket counter at once
module stable_four_level_priority_queue import sflpq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int LEVELS   = LEVELS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [LEVEL_W-1:0]  req_level,
   input  logic [ID_W-1:0]     req_item_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [TICKET_W-1:0] rsp_ticket,
   output logic [LEVEL_W-1:0]  rsp_out_level,
   output logic [ID_W-1:0]     rsp_out_id
);

   cmd_type cmd;

   sflpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sflpq_dpath #(
      .CAPACITY (CAPACITY),
      .LEVELS   (LEVELS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_action    (req_action),
      .req_level     (req_level),
      .req_item_id   (req_item_id),
      .rsp_status    (rsp_status),
      .rsp_ticket    (rsp_ticket),
      .rsp_out_level (rsp_out_level),
      .rsp_out_id    (rsp_out_id)
   );

endmodule
